@@ sv/serial_player_frame_engine_assert.svh @@
// assertion macros for the serial player frame engine
// used by the modules that check their own logic; no other dependencies
`ifndef SERIAL_PLAYER_FRAME_ENGINE_ASSERT_SVH
`define SERIAL_PLAYER_FRAME_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPFE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPFE_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SPFE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPFE_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

@@ sv/spfe_pkg.sv @@
// shared types, constants and lookups of the serial player frame engine
// no dependencies
package spfe_pkg;

    localparam int SPFE_JOBQ_DEPTH = 4;
    localparam int TABLE_DEPTH     = 15;
    localparam int RX_STORE        = 8;   // frame bytes 1 to 8 are kept

    // frame layout
    localparam logic [3:0] POS_SOF     = 4'd0;
    localparam logic [3:0] POS_VERSION = 4'd1;
    localparam logic [3:0] POS_LENGTH  = 4'd2;
    localparam logic [3:0] POS_CMD     = 4'd3;
    localparam logic [3:0] POS_FEEDBACK = 4'd4;
    localparam logic [3:0] POS_PARAM_HI = 4'd5;
    localparam logic [3:0] POS_PARAM_LO = 4'd6;
    localparam logic [3:0] POS_CHK_HI  = 4'd7;
    localparam logic [3:0] POS_CHK_LO  = 4'd8;
    localparam logic [3:0] POS_EOF     = 4'd9;

    localparam logic [7:0] BYTE_SOF     = 8'h7E;
    localparam logic [7:0] BYTE_VERSION = 8'hFF;
    localparam logic [7:0] BYTE_LENGTH  = 8'h06;
    localparam logic [7:0] BYTE_EOF     = 8'hEF;

    // command and reply codes
    localparam logic [7:0] CMD_TRACK     = 8'h03;
    localparam logic [7:0] CMD_MP3_TRACK = 8'h12;
    localparam logic [7:0] CMD_ADVERT    = 8'h13;
    localparam logic [7:0] CMD_FOLDER_3K = 8'h14;
    localparam logic [7:0] CODE_QUERY_MIN = 8'h3F;
    localparam logic [7:0] CODE_ERROR    = 8'h40;
    localparam logic [7:0] CODE_ACK      = 8'h41;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // register map, index is paddr[2]
    localparam logic REG_FEEDBACK_ENABLE  = 1'b0;
    localparam logic REG_RESPONSE_TIMEOUT = 1'b1;

    localparam logic [7:0] ENTRY_CODE [TABLE_DEPTH] = '{
        8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3F, 8'h40, 8'h42, 8'h43,
        8'h44, 8'h47, 8'h48, 8'h4B, 8'h4C, 8'h4E, 8'h4F
    };

    typedef enum logic [1:0] {
        ACT_RX_BYTE = 2'd0,
        ACT_SEND    = 2'd1,
        ACT_TICK    = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_TX      = 3'd0,
        KIND_FRAME   = 3'd1,
        KIND_CHK_ERR = 3'd2,
        KIND_TIMEOUT = 3'd3,
        KIND_READ    = 3'd4
    } t_kind;

    typedef struct packed {
        logic        feedback_enable;
        logic [15:0] response_timeout;
    } t_cfg;

    typedef struct packed {
        t_action     action;
        logic [7:0]  rx_byte;
        logic [7:0]  command;
        logic [15:0] param_low;
        logic [7:0]  param_high;
        logic [3:0]  report_index;
    } t_item;

    // one queued job: a single result, or a whole send frame
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  code;      // send: command byte
        logic [15:0] value;     // send: parameter bytes 5 and 6
        logic        unexp;
        logic        busy;
        logic        feedback;  // send: byte 4
        logic [15:0] chk;       // send: checksum bytes
    } t_job;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [7:0]  code;
        logic [15:0] value;
        logic        unexp;
        logic        busy;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } t_slot;

    function automatic t_slot code_slot(input logic [7:0] code);
        t_slot s;
        s = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (ENTRY_CODE[i] == code) begin
                s.hit = 1'b1;
                s.idx = 4'(i);
            end
        end
        return s;
    endfunction

    // two's complement of the sum of frame bytes 1 to 6
    function automatic logic [15:0] frame_chk(input logic [7:0] b1, input logic [7:0] b2,
                                              input logic [7:0] b3, input logic [7:0] b4,
                                              input logic [7:0] b5, input logic [7:0] b6);
        logic [10:0] sum;
        sum = 11'(b1) + 11'(b2) + 11'(b3) + 11'(b4) + 11'(b5) + 11'(b6);
        return 16'd0 - {5'd0, sum};
    endfunction

endpackage

@@ sv/serial_player_frame_engine.sv @@
// top level of the serial player frame engine: registers, front end, job queue, back end
// depends on spfe_pkg, spfe_regs, spfe_front, spfe_jobq and spfe_back
//
//   channel   handshake                 payload
//   input     push / full               i_action i_rx_byte i_command i_param_low
//                                       i_param_high i_report_index
//   result    empty / pop               o_kind o_tx_byte o_last o_frame_command
//                                       o_value o_unexpected o_busy_res
//   config    psel penable pwrite pready paddr pwdata prdata
//
// the front end takes one item per cycle while full is low and updates all state in that cycle
// each job is registered in the job queue, then in the back end output register
// a send gives ten result transfers, one per cycle while popped, by the back end byte counter
// full rises while the job queue holds JOBQ_DEPTH jobs: a stalled result side, or sends
// arriving faster than their ten transfers drain
// reset is synchronous and clears the report table at once, no clearing pass
module serial_player_frame_engine
    import spfe_pkg::*;
#(
    parameter int JOBQ_DEPTH = SPFE_JOBQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_command,
    input  logic [15:0] i_param_low,
    input  logic [7:0]  i_param_high,
    input  logic [3:0]  i_report_index,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    output logic [7:0]  o_frame_command,
    output logic [15:0] o_value,
    output logic        o_unexpected,
    output logic        o_busy_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    cfg;
    t_item   item;
    t_job    job_in, job_head;
    logic    job_push, q_empty, q_full, q_pop;
    logic    out_valid;
    t_result result;
    logic    accept;

    assign item.action       = t_action'(i_action);
    assign item.rx_byte      = i_rx_byte;
    assign item.command      = i_command;
    assign item.param_low    = i_param_low;
    assign item.param_high   = i_param_high;
    assign item.report_index = i_report_index;

    assign full   = q_full;
    assign accept = push && !q_full;

    spfe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    spfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (item),
        .i_cfg      (cfg),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    spfe_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (q_pop),
        .o_data  (job_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    spfe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (job_head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_valid   (out_valid),
        .o_result  (result)
    );

    assign empty           = !out_valid;
    assign o_kind          = result.kind;
    assign o_tx_byte       = result.tx_byte;
    assign o_last          = result.last;
    assign o_frame_command = result.code;
    assign o_value         = result.value;
    assign o_unexpected    = result.unexp;
    assign o_busy_res      = result.busy;

endmodule

@@ sv/spfe_regs.sv @@
// configuration registers behind the apb-style port
// depends on spfe_pkg
module spfe_regs
    import spfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic        r_feedback_enable;
    logic [15:0] r_response_timeout;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feedback_enable  <= 1'b0;
            r_response_timeout <= TIMEOUT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_FEEDBACK_ENABLE:  r_feedback_enable  <= pwdata[0];
                REG_RESPONSE_TIMEOUT: r_response_timeout <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FEEDBACK_ENABLE:  prdata = {31'd0, r_feedback_enable};
            REG_RESPONSE_TIMEOUT: prdata = {16'd0, r_response_timeout};
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.feedback_enable  = r_feedback_enable;
    assign o_cfg.response_timeout = r_response_timeout;

endmodule

@@ sv/spfe_front.sv @@
// front end: accepts items, deframes replies, keeps protocol state and the report
// table, and turns each item into at most one job; depends on spfe_pkg
module spfe_front
    import spfe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output logic  o_job_push,
    output t_job  o_job
);

    logic [3:0]  r_rx_pos, n_rx_pos;
    logic [15:0] r_ticks, n_ticks;
    logic [7:0]  r_expected, n_expected;
    logic        r_pending, n_pending;
    logic [7:0]  r_rx_bytes [RX_STORE];
    logic [15:0] r_table [TABLE_DEPTH];

    logic        rx_we;
    logic [2:0]  rx_widx;
    logic        tbl_we;
    logic [3:0]  tbl_widx;
    logic [15:0] tbl_wdata;

    logic [15:0] rx_chk;
    logic [7:0]  rx_code;
    logic [15:0] rx_param;
    t_slot       rx_slot;
    logic [7:0]  tx_f4;
    logic [7:0]  tx_f5;
    logic [15:0] tx_chk;
    logic [15:0] tick_next;

    // stored bytes sit one below their frame position
    assign rx_code  = r_rx_bytes[3'(POS_CMD - 4'd1)];
    assign rx_param = {r_rx_bytes[3'(POS_PARAM_HI - 4'd1)],
                       r_rx_bytes[3'(POS_PARAM_LO - 4'd1)]};
    assign rx_chk   = frame_chk(r_rx_bytes[0], r_rx_bytes[1], r_rx_bytes[2],
                                r_rx_bytes[3], r_rx_bytes[4], r_rx_bytes[5]);
    assign rx_slot  = code_slot(rx_code);

    assign tx_f4 = {7'd0, i_cfg.feedback_enable};
    assign tx_chk = frame_chk(BYTE_VERSION, BYTE_LENGTH, i_item.command, tx_f4, tx_f5,
                              i_item.param_low[7:0]);
    assign tick_next = (r_ticks == TICKS_MAX) ? r_ticks : r_ticks + 16'd1;

    always_comb begin
        if (i_item.command == CMD_TRACK || i_item.command == CMD_MP3_TRACK ||
            i_item.command == CMD_ADVERT) begin
            tx_f5 = i_item.param_low[15:8];
        end else if (i_item.command == CMD_FOLDER_3K) begin
            tx_f5 = {i_item.param_high[3:0], 4'd0} | i_item.param_low[15:8];
        end else begin
            tx_f5 = i_item.param_high;
        end
    end

    always_comb begin
        n_rx_pos   = r_rx_pos;
        n_ticks    = r_ticks;
        n_expected = r_expected;
        n_pending  = r_pending;
        rx_we      = 1'b0;
        rx_widx    = 3'(r_rx_pos - 4'd1);
        tbl_we     = 1'b0;
        tbl_widx   = rx_slot.idx;
        tbl_wdata  = rx_param;
        o_job_push = 1'b0;
        o_job      = '0;
        if (i_accept) begin
            unique case (i_item.action)
                ACT_RX_BYTE: begin
                    if (r_rx_pos == POS_SOF) begin
                        // stray first byte is dropped
                        if (i_item.rx_byte == BYTE_SOF) begin
                            n_rx_pos = POS_VERSION;
                            n_ticks  = '0;
                        end
                    end else if (r_rx_pos != POS_EOF) begin
                        rx_we    = 1'b1;
                        n_rx_pos = r_rx_pos + 4'd1;
                    end else begin
                        n_rx_pos   = POS_SOF;
                        o_job_push = 1'b1;
                        o_job.code = rx_code;
                        if (rx_chk != {r_rx_bytes[3'(POS_CHK_HI - 4'd1)],
                                       r_rx_bytes[3'(POS_CHK_LO - 4'd1)]}) begin
                            o_job.kind = KIND_CHK_ERR;
                        end else begin
                            o_job.kind  = KIND_FRAME;
                            o_job.value = rx_param;
                            if (rx_code == CODE_ACK) begin
                                n_pending = 1'b0;
                            end else begin
                                tbl_we = rx_slot.hit;
                            end
                            if (rx_code >= CODE_QUERY_MIN && rx_code != CODE_ERROR &&
                                rx_code != CODE_ACK) begin
                                o_job.unexp = (rx_code != r_expected);
                                n_expected  = '0;
                            end
                        end
                    end
                end
                ACT_SEND: begin
                    o_job_push     = 1'b1;
                    o_job.kind     = KIND_TX;
                    o_job.code     = i_item.command;
                    o_job.value    = {tx_f5, i_item.param_low[7:0]};
                    o_job.feedback = i_cfg.feedback_enable;
                    o_job.chk      = tx_chk;
                    if (i_item.command >= CODE_QUERY_MIN) begin
                        n_expected = i_item.command;
                    end
                    if (i_cfg.feedback_enable) begin
                        n_pending = 1'b1;
                    end
                end
                ACT_TICK: begin
                    if (r_rx_pos != POS_SOF) begin
                        n_ticks = tick_next;
                        if (tick_next > i_cfg.response_timeout) begin
                            n_rx_pos   = POS_SOF;
                            o_job_push = 1'b1;
                            o_job.kind = KIND_TIMEOUT;
                        end
                    end
                end
                ACT_READ: begin
                    o_job_push = 1'b1;
                    o_job.kind = KIND_READ;
                    if (i_item.report_index < 4'(TABLE_DEPTH)) begin
                        o_job.code  = ENTRY_CODE[i_item.report_index];
                        o_job.value = r_table[i_item.report_index];
                    end
                end
                default: ;
            endcase
        end
        // busy flag reflects the state after this item
        o_job.busy = n_pending || (n_expected != 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_pos   <= POS_SOF;
            r_ticks    <= '0;
            r_expected <= '0;
            r_pending  <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_table[i] <= '0;
            end
        end else begin
            r_rx_pos   <= n_rx_pos;
            r_ticks    <= n_ticks;
            r_expected <= n_expected;
            r_pending  <= n_pending;
            if (tbl_we) begin
                r_table[tbl_widx] <= tbl_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_bytes[rx_widx] <= i_item.rx_byte;
        end
    end

endmodule

@@ sv/spfe_jobq.sv @@
// short job queue between the front end and the back end
// depends on spfe_pkg
module spfe_jobq
    import spfe_pkg::*;
#(
    parameter int DEPTH = SPFE_JOBQ_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty,
    output logic o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_store [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_store[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wptr] <= i_data;
        end
    end

endmodule

@@ sv/spfe_back.sv @@
// back end: expands jobs into result transfers and holds the output register
// depends on spfe_pkg and serial_player_frame_engine_assert.svh
`include "serial_player_frame_engine_assert.svh"
module spfe_back
    import spfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_q_data,
    input  logic    i_q_empty,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_result
);

    logic       r_out_valid;
    t_result    r_out, n_out;
    logic [3:0] r_byte_idx, n_byte_idx;
    logic       load;
    logic [7:0] tx_byte;

    assign load = (!r_out_valid || i_pop) && !i_q_empty;

    always_comb begin
        case (r_byte_idx)
            POS_SOF:      tx_byte = BYTE_SOF;
            POS_VERSION:  tx_byte = BYTE_VERSION;
            POS_LENGTH:   tx_byte = BYTE_LENGTH;
            POS_CMD:      tx_byte = i_q_data.code;
            POS_FEEDBACK: tx_byte = {7'd0, i_q_data.feedback};
            POS_PARAM_HI: tx_byte = i_q_data.value[15:8];
            POS_PARAM_LO: tx_byte = i_q_data.value[7:0];
            POS_CHK_HI:   tx_byte = i_q_data.chk[15:8];
            POS_CHK_LO:   tx_byte = i_q_data.chk[7:0];
            POS_EOF:      tx_byte = BYTE_EOF;
            default:      tx_byte = '0;
        endcase
    end

    always_comb begin
        n_out      = '0;
        n_byte_idx = r_byte_idx;
        o_q_pop    = 1'b0;
        n_out.busy = i_q_data.busy;
        if (i_q_data.kind == KIND_TX) begin
            // a send job stays at the head until its tenth byte goes out
            n_out.kind    = KIND_TX;
            n_out.tx_byte = tx_byte;
            n_out.last    = (r_byte_idx == POS_EOF);
            if (load) begin
                if (r_byte_idx == POS_EOF) begin
                    o_q_pop    = 1'b1;
                    n_byte_idx = POS_SOF;
                end else begin
                    n_byte_idx = r_byte_idx + 4'd1;
                end
            end
        end else begin
            n_out.kind  = i_q_data.kind;
            n_out.code  = i_q_data.code;
            n_out.value = i_q_data.value;
            n_out.unexp = i_q_data.unexp;
            o_q_pop     = load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_byte_idx  <= POS_SOF;
        end else begin
            r_byte_idx <= n_byte_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `SPFE_ASSERT_NEVER(a_byte_idx_range, i_clk, i_rst_n, r_byte_idx > POS_EOF, "send byte index past frame end")
    `SPFE_ASSERT(a_send_holds_head, i_clk, i_rst_n, (r_byte_idx != POS_SOF) |-> (!i_q_empty && i_q_data.kind == KIND_TX), "partial send lost its job")
    `SPFE_ASSERT(a_last_is_tx, i_clk, i_rst_n, (r_out_valid && r_out.last) |-> (r_out.kind == KIND_TX), "last flag on a non-transmit result")

endmodule

@@ sim/tb_serial_player_frame_engine.sv @@
// self-checking testbench of serial_player_frame_engine: queued stimulus, random idling
// on both queue sides, apb register setup and an in-order predictor of frames and replies
// depends on spfe_pkg and the serial_player_frame_engine rtl
`timescale 1ns / 1ps

module tb_serial_player_frame_engine;
    import spfe_pkg::*;

    localparam int         CYCLE_LIMIT   = 400_000;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         IDLE_PCT      = 12;
    localparam int         FRAME_LEN     = 10;
    localparam int         MAX_PRINTS    = 40;
    localparam logic [7:0] ACK_REQUEST   = 8'h01;

    typedef logic [7:0] t_frame [FRAME_LEN];

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        push           = 1'b0;
    logic        full;
    logic [1:0]  i_action       = '0;
    logic [7:0]  i_rx_byte      = '0;
    logic [7:0]  i_command      = '0;
    logic [15:0] i_param_low    = '0;
    logic [7:0]  i_param_high   = '0;
    logic [3:0]  i_report_index = '0;
    logic        empty;
    logic        pop            = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic        o_last;
    logic [7:0]  o_frame_command;
    logic [15:0] o_value;
    logic        o_unexpected;
    logic        o_busy_res;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    serial_player_frame_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_action        (i_action),
        .i_rx_byte       (i_rx_byte),
        .i_command       (i_command),
        .i_param_low     (i_param_low),
        .i_param_high    (i_param_high),
        .i_report_index  (i_report_index),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_tx_byte       (o_tx_byte),
        .o_last          (o_last),
        .o_frame_command (o_frame_command),
        .o_value         (o_value),
        .o_unexpected    (o_unexpected),
        .o_busy_res      (o_busy_res),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // engine state as the testbench sees it
    logic        fb_en       = 1'b0;
    logic [15:0] rsp_timeout = TIMEOUT_RESET;
    t_frame      rx_buf      = '{default: 8'h00};
    logic [3:0]  rx_pos      = '0;
    logic [15:0] ticks       = '0;
    logic [7:0]  want_code   = '0;
    logic        fb_pending  = 1'b0;
    logic [15:0] reports [TABLE_DEPTH] = '{default: 16'h0000};

    t_item   item_backlog [$];
    t_result due_results  [$];

    bit          hold_in   = 1'b0;
    bit          calm      = 1'b0;
    bit          in_taken  = 1'b0;
    logic [7:0]  gen_query = '0;
    int          errors    = 0;
    int          cycles    = 0;
    int          n_queued  = 0;
    int          n_items   = 0;
    int          n_checked = 0;
    int          n_sends   = 0;
    int          n_frames  = 0;
    int          n_chk_err = 0;
    int          n_timeouts = 0;
    int          n_reads   = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at result %0d, %s: got %0h, expected %0h",
                     n_checked, what, got, want);
    endtask

    // negated 16-bit sum of bytes 1 to 6
    function automatic logic [15:0] frame_chk16(input t_frame f);
        logic [15:0] s;
        s = '0;
        for (int i = 1; i <= 6; i++)
            s = s + 16'(f[i]);
        return 16'h0000 - s;
    endfunction

    task automatic log_result(input t_kind k, input logic [7:0] txb, input logic lst,
                              input logic [7:0] code, input logic [15:0] val,
                              input logic unexp);
        t_result r;
        r.kind    = k;
        r.tx_byte = txb;
        r.last    = lst;
        r.code    = code;
        r.value   = val;
        r.unexp   = unexp;
        r.busy    = fb_pending || (want_code != 8'h00);
        due_results.push_back(r);
    endtask

    // advance the engine state by one accepted item and queue what it produces
    task automatic step_frame_engine(input t_item it);
        logic [15:0] chk;
        logic [7:0]  code;
        logic [15:0] param;
        logic [15:0] f5w;
        logic        odd;
        t_frame      f;
        case (it.action)
            ACT_RX_BYTE: begin
                if (rx_pos > POS_EOF) rx_pos = POS_SOF;
                rx_buf[rx_pos] = it.rx_byte;
                if (rx_pos != POS_SOF || it.rx_byte == BYTE_SOF) begin
                    if (rx_pos == POS_SOF) ticks = '0;
                    rx_pos++;
                    if (rx_pos == 4'(FRAME_LEN)) begin
                        rx_pos = POS_SOF;
                        chk    = frame_chk16(rx_buf);
                        code   = rx_buf[POS_CMD];
                        if (rx_buf[POS_CHK_HI] != chk[15:8] || rx_buf[POS_CHK_LO] != chk[7:0]) begin
                            n_chk_err++;
                            log_result(KIND_CHK_ERR, 8'h00, 1'b0, code, 16'h0000, 1'b0);
                        end else begin
                            param = {rx_buf[POS_PARAM_HI], rx_buf[POS_PARAM_LO]};
                            odd   = 1'b0;
                            if (code == CODE_ACK) begin
                                fb_pending = 1'b0;
                            end else begin
                                for (int i = 0; i < TABLE_DEPTH; i++)
                                    if (ENTRY_CODE[i] == code) reports[i] = param;
                            end
                            if (code >= CODE_QUERY_MIN && code != CODE_ERROR && code != CODE_ACK) begin
                                odd       = (code != want_code);
                                want_code = '0;
                            end
                            n_frames++;
                            log_result(KIND_FRAME, 8'h00, 1'b0, code, param, odd);
                        end
                    end
                end
            end
            ACT_SEND: begin
                f[POS_SOF]      = BYTE_SOF;
                f[POS_VERSION]  = BYTE_VERSION;
                f[POS_LENGTH]   = BYTE_LENGTH;
                f[POS_CMD]      = it.command;
                f[POS_FEEDBACK] = fb_en ? ACK_REQUEST : 8'h00;
                f[POS_PARAM_LO] = it.param_low[7:0];
                if (it.command == CMD_TRACK || it.command == CMD_MP3_TRACK ||
                    it.command == CMD_ADVERT) begin
                    f[POS_PARAM_HI] = it.param_low[15:8];
                end else if (it.command == CMD_FOLDER_3K) begin
                    // folder in the upper nibble, ored with track bits 15:8
                    f5w             = ({8'h00, it.param_high} << 4) | (it.param_low >> 8);
                    f[POS_PARAM_HI] = f5w[7:0];
                end else begin
                    f[POS_PARAM_HI] = it.param_high;
                end
                chk           = frame_chk16(f);
                f[POS_CHK_HI] = chk[15:8];
                f[POS_CHK_LO] = chk[7:0];
                f[POS_EOF]    = BYTE_EOF;
                if (it.command >= CODE_QUERY_MIN) want_code = it.command;
                if (fb_en) fb_pending = 1'b1;
                n_sends++;
                for (int i = 0; i < FRAME_LEN; i++)
                    log_result(KIND_TX, f[i], i == FRAME_LEN - 1, 8'h00, 16'h0000, 1'b0);
            end
            ACT_TICK: begin
                if (rx_pos != POS_SOF) begin
                    if (ticks != TICKS_MAX) ticks++;
                    if (ticks > rsp_timeout) begin
                        rx_pos = POS_SOF;
                        n_timeouts++;
                        log_result(KIND_TIMEOUT, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0);
                    end
                end
            end
            default: begin
                n_reads++;
                if (it.report_index < 4'(TABLE_DEPTH))
                    log_result(KIND_READ, 8'h00, 1'b0, ENTRY_CODE[it.report_index],
                               reports[it.report_index], 1'b0);
                else
                    log_result(KIND_READ, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0);
            end
        endcase
    endtask

    // unused fields still carry random bits
    function automatic t_item blank_item(input t_action a);
        t_item it;
        it.action       = a;
        it.rx_byte      = 8'($urandom);
        it.command      = 8'($urandom);
        it.param_low    = 16'($urandom);
        it.param_high   = 8'($urandom);
        it.report_index = 4'($urandom);
        return it;
    endfunction

    task automatic queue_item(input t_item it);
        item_backlog.push_back(it);
        n_queued++;
    endtask

    task automatic queue_rx(input logic [7:0] b);
        t_item it;
        it         = blank_item(ACT_RX_BYTE);
        it.rx_byte = b;
        queue_item(it);
    endtask

    task automatic queue_send(input logic [7:0] cmd, input logic [15:0] lo, input logic [7:0] hi);
        t_item it;
        it            = blank_item(ACT_SEND);
        it.command    = cmd;
        it.param_low  = lo;
        it.param_high = hi;
        queue_item(it);
    endtask

    task automatic queue_tick(input int n);
        repeat (n) queue_item(blank_item(ACT_TICK));
    endtask

    task automatic queue_read(input logic [3:0] idx);
        t_item it;
        it              = blank_item(ACT_READ);
        it.report_index = idx;
        queue_item(it);
    endtask

    // a reply frame from the player, optionally with a corrupted checksum, at times odd header or end bytes
    task automatic queue_reply(input logic [7:0] code, input logic [15:0] param, input bit good);
        t_frame      f;
        logic [15:0] chk;
        int          k;
        int          tick_at;
        f[POS_SOF]      = BYTE_SOF;
        f[POS_VERSION]  = ($urandom_range(9) == 0) ? 8'($urandom) : BYTE_VERSION;
        f[POS_LENGTH]   = ($urandom_range(9) == 0) ? 8'($urandom) : BYTE_LENGTH;
        f[POS_CMD]      = code;
        f[POS_FEEDBACK] = 8'($urandom_range(1));
        f[POS_PARAM_HI] = param[15:8];
        f[POS_PARAM_LO] = param[7:0];
        chk             = frame_chk16(f);
        f[POS_CHK_HI]   = chk[15:8];
        f[POS_CHK_LO]   = chk[7:0];
        f[POS_EOF]      = ($urandom_range(9) == 0) ? 8'($urandom) : BYTE_EOF;
        if (!good) begin
            k = $urandom_range(15);
            if (k < 8) f[POS_CHK_LO][k] = ~f[POS_CHK_LO][k];
            else       f[POS_CHK_HI][k - 8] = ~f[POS_CHK_HI][k - 8];
        end
        // one tick inside the frame stays within any nonzero timeout
        tick_at = ($urandom_range(4) == 0 && rsp_timeout != 16'd0) ? $urandom_range(1, 9) : 0;
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (i == tick_at && i != 0) queue_tick(1);
            queue_rx(f[i]);
        end
    endtask

    function automatic logic [15:0] pick_param();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_traffic(input int n);
        int          stop_at;
        int          r;
        logic [7:0]  code;
        stop_at = n_queued + n;
        while (n_queued < stop_at) begin
            r = $urandom_range(99);
            if (r < 35) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: code = (gen_query != 8'h00) ? gen_query
                                                            : ENTRY_CODE[$urandom_range(14)];
                    4, 5, 6:    code = ENTRY_CODE[$urandom_range(14)];
                    7:          code = CODE_ACK;
                    8:          code = 8'($urandom);
                    default:    code = ENTRY_CODE[$urandom_range(3)];
                endcase
                if (code >= CODE_QUERY_MIN && code != CODE_ERROR && code != CODE_ACK)
                    gen_query = '0;
                queue_reply(code, pick_param(), $urandom_range(99) < 85);
            end else if (r < 55) begin
                case ($urandom_range(9))
                    0:       code = CMD_TRACK;
                    1:       code = CMD_MP3_TRACK;
                    2:       code = CMD_ADVERT;
                    3:       code = CMD_FOLDER_3K;
                    4, 5:    code = ENTRY_CODE[$urandom_range(4, 14)];
                    default: code = 8'($urandom);
                endcase
                if (code >= CODE_QUERY_MIN) gen_query = code;
                queue_send(code, pick_param(), 8'($urandom));
            end else if (r < 70) begin
                queue_read(4'($urandom_range(15)));
            end else if (r < 80) begin
                // partial frame left to time out
                queue_rx(BYTE_SOF);
                repeat ($urandom_range(8)) queue_rx(8'($urandom));
                queue_tick(int'(rsp_timeout) + 1);
            end else if (r < 88) begin
                queue_tick($urandom_range(1, 3));
            end else begin
                // noise, then enough ticks to drop any partial frame
                repeat ($urandom_range(1, 4)) queue_item(blank_item(t_action'($urandom_range(3))));
                queue_tick(int'(rsp_timeout) + 1);
            end
        end
    endtask

    task automatic wait_drained();
        while (item_backlog.size() != 0 || push) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic sel, input logic [31:0] wd,
                            output logic [31:0] rd);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= wd;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write a register, track it, read it back
    task automatic cfg_write(input logic sel, input logic [31:0] v);
        logic [31:0] rd;
        apb_xfer(1'b1, sel, v, rd);
        if (sel == REG_FEEDBACK_ENABLE) fb_en = v[0];
        else                            rsp_timeout = v[15:0];
        apb_xfer(1'b0, sel, 32'd0, rd);
        if (sel == REG_FEEDBACK_ENABLE) begin
            if (rd[0] !== fb_en) report_mismatch("feedback_enable readback", rd, 32'(fb_en));
        end else if (rd[15:0] !== rsp_timeout) begin
            report_mismatch("response_timeout readback", rd, 32'(rsp_timeout));
        end
    endtask

    // input side: present the oldest pending item, hold it until the transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !in_taken) begin
            // stalled by full, keep the item on the ports
        end else if (item_backlog.size() != 0 && !hold_in &&
                     (calm || $urandom_range(99) >= IDLE_PCT)) begin
            push           <= 1'b1;
            i_action       <= item_backlog[0].action;
            i_rx_byte      <= item_backlog[0].rx_byte;
            i_command      <= item_backlog[0].command;
            i_param_low    <= item_backlog[0].param_low;
            i_param_high   <= item_backlog[0].param_high;
            i_report_index <= item_backlog[0].report_index;
        end else begin
            push <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        in_taken = i_rst_n && push && !full;
        if (in_taken) begin
            step_frame_engine(item_backlog.pop_front());
            n_items++;
        end
    end

    // result side
    always @(negedge i_clk) begin
        if (!i_rst_n) pop <= 1'b0;
        else          pop <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing expected, kind", 32'(o_kind), 32'd0);
            end else begin
                want = due_results.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch("kind", 32'(o_kind), 32'(want.kind));
                if (o_tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", 32'(o_tx_byte), 32'(want.tx_byte));
                if (o_last !== want.last)
                    report_mismatch("last", 32'(o_last), 32'(want.last));
                if (o_frame_command !== want.code)
                    report_mismatch("frame_command", 32'(o_frame_command), 32'(want.code));
                if (o_value !== want.value)
                    report_mismatch("value", 32'(o_value), 32'(want.value));
                if (o_unexpected !== want.unexp)
                    report_mismatch("unexpected", 32'(o_unexpected), 32'(want.unexp));
                if (o_busy_res !== want.busy)
                    report_mismatch("busy_res", 32'(o_busy_res), 32'(want.busy));
            end
            n_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, due_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // defaults: empty table, stray bytes, idle tick, every send packing, replies
        queue_read(4'd0);
        queue_read(4'd15);
        queue_tick(1);
        queue_rx(8'h00);
        queue_rx(8'hFF);
        queue_send(CMD_TRACK, 16'hFFFF, 8'hFF);
        queue_send(CMD_FOLDER_3K, 16'h0ABC, 8'hFF);
        queue_send(CMD_MP3_TRACK, 16'h1234, 8'h00);
        queue_send(CMD_ADVERT, 16'h0000, 8'h00);
        queue_send(8'h00, 16'h0000, 8'h00);
        queue_send(8'hFF, 16'hFFFF, 8'hFF);
        queue_send(8'h42, 16'h5A5A, 8'hA5);
        queue_reply(8'h42, 16'hFFFF, 1'b1);
        queue_reply(8'h3A, 16'h1111, 1'b0);
        queue_reply(8'h50, 16'h2222, 1'b1);
        queue_reply(8'h4F, 16'hFFFF, 1'b1);
        queue_reply(CODE_ACK, 16'h0000, 1'b1);
        queue_read(4'd6);
        queue_read(4'd14);
        queue_read(4'd0);
        // partial frame stays open under the reset timeout
        queue_rx(BYTE_SOF);
        queue_rx(8'h11);
        queue_tick(3);
        wait_drained();

        // zero timeout expires on the first tick of an open frame; acknowledged sends
        cfg_write(REG_FEEDBACK_ENABLE, 32'd1);
        cfg_write(REG_RESPONSE_TIMEOUT, 32'd0);
        queue_tick(1);
        queue_rx(BYTE_SOF);
        queue_tick(1);
        queue_send(8'h01, 16'h0005, 8'h00);
        queue_reply(CODE_ACK, 16'h0000, 1'b1);
        queue_send(CODE_QUERY_MIN, 16'h0000, 8'h00);
        queue_reply(CODE_QUERY_MIN, 16'h0102, 1'b1);
        wait_drained();

        // random traffic with no idling at all
        cfg_write(REG_FEEDBACK_ENABLE, 32'd0);
        cfg_write(REG_RESPONSE_TIMEOUT, 32'd1);
        calm = 1'b1;
        random_traffic(90);
        wait_drained();
        calm = 1'b0;

        // random traffic, sender held once until every result is out
        cfg_write(REG_FEEDBACK_ENABLE, 32'd1);
        cfg_write(REG_RESPONSE_TIMEOUT, 32'd8);
        random_traffic(45);
        while (item_backlog.size() > 20) @(posedge i_clk);
        hold_in = 1'b1;
        while (push || due_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        hold_in = 1'b0;
        random_traffic(45);
        wait_drained();

        // an open frame survives ticks under a long timeout, then a short one drops it at once
        cfg_write(REG_RESPONSE_TIMEOUT, 32'd65535);
        queue_rx(BYTE_SOF);
        repeat (3) queue_rx(8'($urandom));
        queue_tick(10);
        wait_drained();
        cfg_write(REG_FEEDBACK_ENABLE, 32'd0);
        cfg_write(REG_RESPONSE_TIMEOUT, 32'd3);
        queue_tick(1);
        random_traffic(70);
        wait_drained();

        // back to the reset timeout, dump the whole table
        cfg_write(REG_FEEDBACK_ENABLE, 32'd1);
        cfg_write(REG_RESPONSE_TIMEOUT, 32'(TIMEOUT_RESET));
        queue_send(8'h48, 16'h0000, 8'h00);
        for (int i = 0; i < 16; i++) queue_read(4'(i));
        wait_drained();

        $display("covered %0d items: %0d sends, %0d frames accepted, %0d checksum errors,",
                 n_items, n_sends, n_frames, n_chk_err);
        $display("%0d receive timeouts, %0d table reads; %0d result transfers checked",
                 n_timeouts, n_reads, n_checked);
        if (errors == 0 && due_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/spfe_pkg.sv
sv/spfe_regs.sv
sv/spfe_front.sv
sv/spfe_jobq.sv
sv/spfe_back.sv
sv/serial_player_frame_engine.sv
sim/tb_serial_player_frame_engine.sv
